/* rtl/core/deadline_profit_greedy_scheduler_macros.svh */
// Assertion macros for the deadline/profit scheduler.
// Included by the top level; no other dependencies.
`ifndef DEADLINE_PROFIT_GREEDY_SCHEDULER_MACROS_SVH
`define DEADLINE_PROFIT_GREEDY_SCHEDULER_MACROS_SVH
`ifndef SYNTHESIS
`define DPGS_ASSERT(label, clk_s, rst_n, prop) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define DPGS_ASSERT_IMPL(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define DPGS_ASSERT(label, clk_s, rst_n, prop)
`define DPGS_ASSERT_IMPL(label, clk_s, rst_n, ante, cons)
`endif
`endif

/* rtl/core/dpgs_pkg.sv */
// Shared types and constants for the deadline/profit scheduler.
// No dependencies.
package dpgs_pkg;
	localparam int UnitW  = 40;
	localparam int DayW   = 40;
	localparam int WorthW = 20;
	localparam int TotW   = 63;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_SORT_RD,
		ST_SORT_KEY,
		ST_SORT_CMP,
		ST_SORT_PUT,
		ST_WALK_BASE,
		ST_WALK_NEXT,
		ST_WALK_CMP,
		ST_FILL,
		ST_SCAN,
		ST_TAKE,
		ST_WB,
		ST_ADD_LO,
		ST_ADD_HI,
		ST_OUT
	} state_t;
endpackage

/* rtl/core/dpgs_ram.sv */
// Generic single-write RAM with registered read.
// No dependencies.
module dpgs_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr,
	input  logic [Width-1:0]                              wdata,
	input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr,
	output logic [Width-1:0]                              rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

/* rtl/core/deadline_profit_greedy_scheduler.sv */
// Deadline/profit greedy scheduler, top level; uses dpgs_pkg, dpgs_ram and the macro header.
// Loads one word per cycle; after the last word it runs an insertion sort by falling deadline,
// then an interval walk, and per pick a scan of the usable kinds followed by the take,
// write-back and two-step add states.
// Throughput: one set at a time; input not ready from the last word until the total is taken.
// Asynchronous active-low reset returns to loading with the counters and total cleared.
`include "deadline_profit_greedy_scheduler_macros.svh"
module deadline_profit_greedy_scheduler #(
	parameter int MAX_KINDS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [dpgs_pkg::UnitW-1:0]  unit_count,
	input  logic [dpgs_pkg::DayW-1:0]   deadline_day,
	input  logic [dpgs_pkg::WorthW-1:0] unit_value,
	input  logic                      last_kind,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [dpgs_pkg::TotW-1:0]   total_value
);
	import dpgs_pkg::*;

	localparam int AW = (MAX_KINDS > 1) ? $clog2(MAX_KINDS) : 1;
	localparam int CW = $clog2(MAX_KINDS + 1);
	localparam int EW = UnitW + DayW + WorthW;
	localparam int RestW = DayW + WorthW;
	localparam int HalfW = UnitW / 2;
	localparam logic [CW-1:0] MaxCnt = CW'(MAX_KINDS);
	localparam logic [TotW-1:0] MaxTot = {TotW{1'b1}};

	state_t state_q, state_d;

	logic [CW-1:0]   cnt_q;      // kinds held
	logic [CW-1:0]   i_q;        // sort outer / walk index
	logic [CW-1:0]   j_q;        // sort inner / scan index
	logic [CW-1:0]   lim_q;      // kinds usable in this interval
	logic            final_q;
	logic [EW-1:0]   key_q;      // word being inserted
	logic [DayW-1:0] cur_dl_q, days_q;
	logic [TotW-1:0] tot_q;
	logic [AW-1:0]   best_q;
	logic [WorthW-1:0] bw_q;
	logic            found_q;
	logic [UnitW-1:0] bunits_q, take_q;
	logic [RestW-1:0] brest_q;
	logic [HalfW+WorthW-1:0] prod_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;

	dpgs_ram #(.Width(EW), .Depth(MAX_KINDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [UnitW-1:0]  r_units;
	logic [DayW-1:0]   r_dl, k_dl;
	logic [WorthW-1:0] r_w;
	assign r_units = rdata[EW-1 -: UnitW];
	assign r_dl    = rdata[WorthW +: DayW];
	assign r_w     = rdata[WorthW-1:0];
	assign k_dl    = key_q[WorthW +: DayW];

	logic [WorthW-1:0] in_w;
	assign in_w = (unit_value == '0) ? WorthW'(1) : unit_value;

	logic shift_c, last_scan;
	assign shift_c   = (r_dl < k_dl);
	assign last_scan = ((j_q + CW'(1)) >= lim_q);

	logic [UnitW-1:0] take_c;
	assign take_c = (bunits_q < days_q) ? bunits_q : days_q;

	// shared 20x20 multiplier, low half of take first
	logic [HalfW-1:0]        mul_a;
	logic [HalfW+WorthW-1:0] mul_p;
	assign mul_a = (state_q == ST_WB) ? take_q[HalfW-1:0] : take_q[UnitW-1:HalfW];
	assign mul_p = mul_a * bw_q;

	logic [TotW-1:0] addend, sum;
	logic            ovf;
	assign addend = (state_q == ST_ADD_HI) ? TotW'({prod_q, {HalfW{1'b0}}}) : TotW'(prod_q);
	assign {ovf, sum} = {1'b0, tot_q} + {1'b0, addend};

	assign in_ready = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_OUT);
	assign total_value = tot_q;

	always_comb begin
		state_d = state_q;
		we = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = {unit_count, deadline_day, in_w};
		raddr = '0;
		unique case (state_q)
			ST_LOAD: begin
				we = in_valid && (cnt_q < MaxCnt);
				if (in_valid && last_kind) begin
					state_d = ST_SORT_RD;
				end
			end
			ST_SORT_RD: begin
				if (i_q >= cnt_q) begin
					state_d = ST_WALK_BASE;
				end else begin
					raddr = i_q[AW-1:0];
					state_d = ST_SORT_KEY;
				end
			end
			ST_SORT_KEY: begin
				raddr = AW'(j_q - CW'(1));
				state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				waddr = j_q[AW-1:0];
				we = 1'b1;
				if (shift_c) begin
					wdata = rdata;
					raddr = AW'(j_q - CW'(2));
					if (j_q == CW'(1)) begin
						state_d = ST_SORT_PUT;
					end
				end else begin
					wdata = key_q;
					state_d = ST_SORT_RD;
				end
			end
			ST_SORT_PUT: begin
				waddr = '0;
				we = 1'b1;
				wdata = key_q;
				state_d = ST_SORT_RD;
			end
			ST_WALK_BASE: begin
				state_d = ST_WALK_NEXT;
			end
			ST_WALK_NEXT: begin
				if (i_q >= cnt_q) begin
					state_d = ST_FILL;
				end else begin
					raddr = i_q[AW-1:0];
					state_d = ST_WALK_CMP;
				end
			end
			ST_WALK_CMP: begin
				state_d = (r_dl != cur_dl_q) ? ST_FILL : ST_WALK_NEXT;
			end
			ST_FILL: begin
				if (days_q == '0) begin
					state_d = final_q ? ST_OUT : ST_WALK_NEXT;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				raddr = AW'(j_q + CW'(1));
				if (last_scan) begin
					state_d = ST_TAKE;
				end
			end
			ST_TAKE: begin
				if (found_q) begin
					state_d = ST_WB;
				end else begin
					state_d = final_q ? ST_OUT : ST_WALK_NEXT;
				end
			end
			ST_WB: begin
				waddr = best_q;
				we = 1'b1;
				wdata = {bunits_q - take_q, brest_q};
				state_d = ST_ADD_LO;
			end
			ST_ADD_LO: begin
				state_d = ST_ADD_HI;
			end
			ST_ADD_HI: begin
				state_d = ST_FILL;
			end
			ST_OUT: begin
				if (out_ready) begin
					state_d = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			lim_q <= '0;
			final_q <= 1'b0;
			key_q <= '0;
			cur_dl_q <= '0;
			days_q <= '0;
			tot_q <= '0;
			best_q <= '0;
			bw_q <= '0;
			found_q <= 1'b0;
			bunits_q <= '0;
			take_q <= '0;
			brest_q <= '0;
			prod_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (in_valid) begin
						if (cnt_q < MaxCnt) begin
							cnt_q <= cnt_q + CW'(1);
						end
						if (last_kind) begin
							i_q <= CW'(1);
							tot_q <= '0;
						end
					end
				end
				ST_SORT_RD: begin
					if (i_q >= cnt_q) begin
						i_q <= CW'(1);
					end else begin
						j_q <= i_q;
					end
				end
				ST_SORT_KEY: begin
					key_q <= rdata;
				end
				ST_SORT_CMP: begin
					if (shift_c) begin
						j_q <= j_q - CW'(1);
					end else begin
						i_q <= i_q + CW'(1);
					end
				end
				ST_SORT_PUT: begin
					i_q <= i_q + CW'(1);
				end
				ST_WALK_BASE: begin
					cur_dl_q <= r_dl;
					final_q <= 1'b0;
				end
				ST_WALK_NEXT: begin
					if (i_q >= cnt_q) begin
						days_q <= cur_dl_q;
						lim_q <= cnt_q;
						final_q <= 1'b1;
					end
				end
				ST_WALK_CMP: begin
					i_q <= i_q + CW'(1);
					if (r_dl != cur_dl_q) begin
						days_q <= cur_dl_q - r_dl;
						lim_q <= i_q;
						cur_dl_q <= r_dl;
					end
				end
				ST_FILL: begin
					j_q <= '0;
					bw_q <= '0;
					found_q <= 1'b0;
				end
				ST_SCAN: begin
					if (r_units != '0 && r_w > bw_q) begin
						bw_q <= r_w;
						best_q <= j_q[AW-1:0];
						found_q <= 1'b1;
						bunits_q <= r_units;
						brest_q <= rdata[RestW-1:0];
					end
					j_q <= j_q + CW'(1);
				end
				ST_TAKE: begin
					take_q <= take_c;
				end
				ST_WB: begin
					days_q <= days_q - take_q;
					prod_q <= mul_p;
				end
				ST_ADD_LO: begin
					tot_q <= ovf ? MaxTot : sum;
					prod_q <= mul_p;
				end
				ST_ADD_HI: begin
					tot_q <= ovf ? MaxTot : sum;
				end
				ST_OUT: begin
					if (out_ready) begin
						cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	`DPGS_ASSERT_IMPL(a_ready_load, clk, arst_n, in_ready, state_q == ST_LOAD)
	`DPGS_ASSERT_IMPL(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= MaxCnt)
	`DPGS_ASSERT_IMPL(a_out_excl, clk, arst_n, out_valid, !in_ready)
	`DPGS_ASSERT_IMPL(a_scan_range, clk, arst_n, state_q == ST_SCAN, j_q < lim_q)
	`DPGS_ASSERT_IMPL(a_out_hold, clk, arst_n, out_valid && !out_ready,
		##1 (out_valid && $stable(total_value)))
endmodule
